FILE: hdl/centered_moving_average_unit_assert.svh
// Assertion macros for the RTL of the centered moving average unit.
`ifndef CENTERED_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define CENTERED_MOVING_AVERAGE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define CMAVG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cmavg assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define CMAVG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cmavg assertion failed");
`else
`define CMAVG_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CMAVG_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hdl/cmavg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cmavg_pkg;

    localparam int SAMPLE_W     = 24;
    localparam int CFG_W        = 5;
    localparam int DEF_MAX_HALF = 16;

    localparam logic [CFG_W-1:0] WINDOW_HALF_RST = CFG_W'(1);

    // Width of a signed sum over a window of win_len samples.
    function automatic int sum_width(input int win_len);
        return SAMPLE_W + $clog2(win_len);
    endfunction

endpackage
`default_nettype wire

FILE: hdl/cmavg_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One cell of the prefix-sum chain: holds the sum of the newest samples up to its
// own position and, on each new sample, takes its neighbor's sum plus that sample.
module cmavg_cell
    import cmavg_pkg::*;
#(
    parameter int SUM_W = SAMPLE_W + 6
) (
    input  wire logic                       aclk,
    input  wire logic                       shift_en,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic signed [SUM_W-1:0]    prev_sum,
    output logic signed [SUM_W-1:0]         sum
);

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;

    always_comb begin
        sum_next = sum_reg;
        if (shift_en) begin
            sum_next = SUM_W'(sample) + prev_sum;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule
`default_nettype wire

FILE: hdl/cmavg_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Signed divide by a small count, truncating toward zero: magnitude times a
// reciprocal from a constant table, then one compare-and-correct step.
module cmavg_div
    import cmavg_pkg::*;
#(
    parameter int MAX_HALF_WINDOW = DEF_MAX_HALF
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        in_valid,
    output logic                                             in_ready,
    input  wire logic signed [sum_width(2*MAX_HALF_WINDOW+1)-1:0] in_sum,
    input  wire logic [$clog2(2*MAX_HALF_WINDOW+2)-1:0]      in_count,
    input  wire logic                                        in_last,
    output logic                                             m_valid,
    input  wire logic                                        m_ready,
    output logic signed [SAMPLE_W-1:0]                       m_average,
    output logic                                             m_last_out
);

    localparam int WIN_LEN = 2 * MAX_HALF_WINDOW + 1;
    localparam int CNT_W   = $clog2(WIN_LEN + 1);
    localparam int SUM_W   = sum_width(WIN_LEN);
    localparam int MAG_W   = SUM_W - 1;
    localparam int RCP_W   = SUM_W + 1;
    localparam int PROD_W  = MAG_W + RCP_W;
    localparam int TAB_N   = 2 ** CNT_W;

    // reciprocal table: floor((2^RCP_W - 1) / n); entry 0 is never used
    logic [RCP_W-1:0] recip_tab [TAB_N];

    genvar g;
    generate
        for (g = 0; g < TAB_N; g++) begin : g_recip
            localparam longint DIVR = (g == 0) ? 1 : g;
            localparam logic [RCP_W-1:0] RV =
                RCP_W'(((64'd1 << RCP_W) - 64'd1) / DIVR);
            assign recip_tab[g] = RV;
        end
    endgenerate

    logic               v1_reg, v1_next;
    logic               v2_reg, v2_next;
    logic               ov_reg, ov_next;
    logic [MAG_W-1:0]   mag1_reg, mag2_reg;
    logic [CNT_W-1:0]   cnt1_reg, cnt2_reg;
    logic [RCP_W-1:0]   rcp1_reg;
    logic               neg1_reg, neg2_reg;
    logic               last1_reg, last2_reg, last3_reg;
    logic [PROD_W-1:0]  prod2_reg;
    logic [SAMPLE_W-1:0] avg3_reg;

    logic               adv1, adv2, load1;
    logic [MAG_W-1:0]   mag_in;
    logic [MAG_W-1:0]   q0;
    logic [MAG_W+CNT_W-1:0] qn_full;
    logic [MAG_W-1:0]   rem;
    logic [MAG_W-1:0]   q_fix;
    logic [MAG_W-1:0]   q_signed;

    assign adv2     = v2_reg && (!ov_reg || m_ready);
    assign adv1     = v1_reg && (!v2_reg || adv2);
    assign in_ready = !v1_reg || adv1;
    assign load1    = in_valid && in_ready;

    assign mag_in = in_sum[SUM_W-1] ? MAG_W'(-in_sum) : MAG_W'(in_sum);

    // correction step: estimate is exact or one short
    assign q0       = MAG_W'(prod2_reg >> RCP_W);
    assign qn_full  = (MAG_W+CNT_W)'(q0) * (MAG_W+CNT_W)'(cnt2_reg);
    assign rem      = mag2_reg - MAG_W'(qn_full);
    assign q_fix    = (rem >= MAG_W'(cnt2_reg)) ? q0 + MAG_W'(1) : q0;
    assign q_signed = neg2_reg ? (~q_fix + MAG_W'(1)) : q_fix;

    always_comb begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        ov_next = ov_reg;
        if (adv1) begin
            v1_next = 1'b0;
        end
        if (load1) begin
            v1_next = 1'b1;
        end
        if (adv2) begin
            v2_next = 1'b0;
        end
        if (adv1) begin
            v2_next = 1'b1;
        end
        if (m_valid && m_ready) begin
            ov_next = 1'b0;
        end
        if (adv2) begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load1) begin
            mag1_reg  <= mag_in;
            cnt1_reg  <= in_count;
            rcp1_reg  <= recip_tab[in_count];
            neg1_reg  <= in_sum[SUM_W-1];
            last1_reg <= in_last;
        end
        if (adv1) begin
            prod2_reg <= PROD_W'(mag1_reg) * PROD_W'(rcp1_reg);
            mag2_reg  <= mag1_reg;
            cnt2_reg  <= cnt1_reg;
            neg2_reg  <= neg1_reg;
            last2_reg <= last1_reg;
        end
        if (adv2) begin
            avg3_reg  <= q_signed[SAMPLE_W-1:0];
            last3_reg <= last2_reg;
        end
    end

    assign m_valid    = ov_reg;
    assign m_average  = avg3_reg;
    assign m_last_out = last3_reg;

endmodule
`default_nettype wire

FILE: hdl/centered_moving_average_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Centered moving average over a stream of signed Q15.8 samples. Each result beat is
// the mean of one stream position and up to window_half neighbors on each side,
// truncated toward zero; neighbors outside the stream are left out, so the divisor
// shrinks at both ends. Results lag the input by window_half positions, and the beat
// flagged is_last flushes every pending position, the final one flagged last_out;
// the unit then starts a fresh stream. Writing window_half (values above
// MAX_HALF_WINDOW saturate) also restarts the stream; write it only while idle.
// Flow: a sample that yields one result is accepted, then issued to the divider; a
// sample that yields none is only accepted; the last sample of a stream issues
// min(window_half, samples so far - 1) + 1 results, one issue per cycle while the
// divider accepts them. Each result passes through the divider pipeline (select and
// table lookup, reciprocal multiply, correction). The state is a chain of
// 2*MAX_HALF_WINDOW+1 prefix-sum cells, so any window sum is a single cell read.
module centered_moving_average_unit
    import cmavg_pkg::*;
#(
    parameter int MAX_HALF_WINDOW = DEF_MAX_HALF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [CFG_W-1:0]           cfg_wr_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_sample,
    input  wire logic                       s_is_last,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_average,
    output logic                            m_last_out
);

`include "centered_moving_average_unit_assert.svh"

    localparam int WIN_LEN = 2 * MAX_HALF_WINDOW + 1;
    localparam int IDX_W   = $clog2(WIN_LEN);
    localparam int CNT_W   = $clog2(WIN_LEN + 1);
    localparam int SUM_W   = sum_width(WIN_LEN);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   k_reg, k_next;
    logic [CFG_W-1:0]   d_reg, d_next;
    logic [CNT_W-1:0]   seen_reg, seen_next;
    logic               last_reg, last_next;

    logic               in_beat;
    logic [CNT_W-1:0]   seen_inc;
    logic [CFG_W-1:0]   cfg_sat;
    logic [CFG_W:0]     d_plus_k;
    logic [CNT_W-1:0]   seen_m1;
    logic [IDX_W-1:0]   hi_idx;
    logic [CNT_W-1:0]   div_count;
    logic               div_in_valid;
    logic               div_in_ready;
    logic               div_in_last;
    logic               issue;

    logic signed [SUM_W-1:0] cell_sum [WIN_LEN];

    assign s_ready = (state_reg == ST_IDLE);
    assign in_beat = s_valid && s_ready;

    // Shift the prefix chain: cell i takes its newer neighbor's sum plus the sample.
    genvar g;
    generate
        for (g = 0; g < WIN_LEN; g++) begin : g_cell
            logic signed [SUM_W-1:0] prev_sum;
            if (g == 0) begin : g_head
                assign prev_sum = '0;
            end else begin : g_link
                assign prev_sum = cell_sum[g-1];
            end
            cmavg_cell #(
                .SUM_W(SUM_W)
            ) u_cell (
                .aclk    (aclk),
                .shift_en(in_beat),
                .sample  (s_sample),
                .prev_sum(prev_sum),
                .sum     (cell_sum[g])
            );
        end
    endgenerate

    // Count samples of this stream, saturating at the chain length.
    assign seen_inc = (seen_reg < CNT_W'(WIN_LEN)) ? seen_reg + CNT_W'(1) : seen_reg;

    // Clamp the configured half width.
    assign cfg_sat = (32'(cfg_wr_data) > 32'(MAX_HALF_WINDOW)) ?
                     CFG_W'(MAX_HALF_WINDOW) : cfg_wr_data;

    // Window for center d covers cells 0 through min(d + k, seen - 1).
    assign d_plus_k  = (CFG_W+1)'(d_reg) + (CFG_W+1)'(k_reg);
    assign seen_m1   = seen_reg - CNT_W'(1);
    assign hi_idx    = (32'(d_plus_k) < 32'(seen_m1)) ? IDX_W'(d_plus_k) : IDX_W'(seen_m1);
    assign div_count = CNT_W'(hi_idx) + CNT_W'(1);

    assign div_in_valid = (state_reg == ST_RUN);
    assign div_in_last  = last_reg && (d_reg == '0);
    assign issue        = div_in_valid && div_in_ready;

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        d_next     = d_reg;
        seen_next  = seen_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    seen_next = seen_inc;
                    last_next = s_is_last;
                    if (s_is_last) begin
                        // flush starts at the oldest pending center
                        d_next = (32'(k_reg) < 32'(seen_inc - CNT_W'(1))) ?
                                 k_reg : CFG_W'(seen_inc - CNT_W'(1));
                        state_next = ST_RUN;
                    end else if (32'(k_reg) < 32'(seen_inc)) begin
                        d_next     = k_reg;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (issue) begin
                    if (last_reg && (d_reg != '0)) begin
                        d_next = d_reg - CFG_W'(1);
                    end else begin
                        state_next = ST_IDLE;
                        if (last_reg) begin
                            // drop the stream once its final position is issued
                            seen_next = '0;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_wr_en) begin
            k_next    = cfg_sat;
            seen_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= WINDOW_HALF_RST;
            d_reg     <= '0;
            seen_reg  <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            d_reg     <= d_next;
            seen_reg  <= seen_next;
            last_reg  <= last_next;
        end
    end

    cmavg_div #(
        .MAX_HALF_WINDOW(MAX_HALF_WINDOW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_in_valid),
        .in_ready  (div_in_ready),
        .in_sum    (cell_sum[hi_idx]),
        .in_count  (div_count),
        .in_last   (div_in_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_average (m_average),
        .m_last_out(m_last_out)
    );

    `CMAVG_ASSERT_IMP(a_center_in_half, aclk, aresetn, state_reg == ST_RUN, d_reg <= k_reg)
    `CMAVG_ASSERT_IMP(a_center_seen, aclk, aresetn, state_reg == ST_RUN, 32'(d_reg) < 32'(seen_reg))
    `CMAVG_ASSERT_NXT(a_flush_clears, aclk, aresetn, issue && div_in_last, seen_reg == '0)

endmodule
`default_nettype wire

FILE: dv/centered_moving_average_unit_tb.sv
`timescale 1ns / 1ps
module centered_moving_average_unit_tb;
    import cmavg_pkg::*;

    localparam int HALF_MAX      = DEF_MAX_HALF;
    localparam int LINE_LEN      = 2 * HALF_MAX + 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int TARGET_BEATS  = 365;
    localparam int PRESSURE_HOLD = 400;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;
    typedef enum int {STYLE_MIXED, STYLE_TOP, STYLE_BOTTOM, STYLE_NEAR_ZERO} stream_style_t;

    typedef struct {
        sample_t average;
        logic    last_out;
    } mean_beat_t;

    // One line of the directed plan; want_* is only used where typed is set.
    typedef struct {
        row_kind_t        kind;
        logic [CFG_W-1:0] half;
        sample_t          sample;
        logic             last;
        bit               typed;
        sample_t          want_avg;
        logic             want_last;
    } row_t;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    sample_t          s_sample    = '0;
    logic             s_is_last   = 1'b0;
    logic             m_ready     = 1'b0;
    wire              s_ready;
    wire              m_valid;
    wire sample_t     m_average;
    wire              m_last_out;

    // Mirror of the unit's stream state: newest sample at entry 0.
    sample_t    history [LINE_LEN];
    int         stream_depth = 0;
    int         half_width   = int'(WINDOW_HALF_RST);
    mean_beat_t means_due [$];

    int          mismatches   = 0;
    int          beats_sent   = 0;
    int unsigned ready_hold   = 0;
    bit          send_steady  = 1'b0;
    bit          recv_steady  = 1'b0;

    // Directed plan. The unit comes out of reset with window_half = 1.
    row_t plan [25] = '{
        // single-sample streams at both extremes pass through
        '{ROW_BEAT, 5'd0,  24'h7FFFFF, 1'b1, 1'b1, 24'h7FFFFF, 1'b1},
        '{ROW_BEAT, 5'd0,  24'h800000, 1'b1, 1'b1, 24'h800000, 1'b1},
        // negative pair: the mean truncates toward zero
        '{ROW_BEAT, 5'd0,  24'hFFFFFF, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_BEAT, 5'd0,  24'hFFFFFE, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_BEAT, 5'd0,  24'h7FFFFF, 1'b1, 1'b0, 24'h000000, 1'b0},
        // zero window: straight pass-through
        '{ROW_CFG,  5'd0,  24'h000000, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_BEAT, 5'd0,  24'h7FFFFF, 1'b0, 1'b1, 24'h7FFFFF, 1'b0},
        '{ROW_BEAT, 5'd0,  24'h800000, 1'b0, 1'b1, 24'h800000, 1'b0},
        '{ROW_BEAT, 5'd0,  24'h555555, 1'b1, 1'b1, 24'h555555, 1'b1},
        // oversize window saturates; short stream flushes every position
        '{ROW_CFG,  5'd31, 24'h000000, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_BEAT, 5'd0,  24'h7FFFFF, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_BEAT, 5'd0,  24'h7FFFFF, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_BEAT, 5'd0,  24'h7FFFFF, 1'b1, 1'b0, 24'h000000, 1'b0},
        '{ROW_CFG,  5'd16, 24'h000000, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_BEAT, 5'd0,  24'h800000, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_BEAT, 5'd0,  24'h800000, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_BEAT, 5'd0,  24'h800000, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_BEAT, 5'd0,  24'h800000, 1'b1, 1'b0, 24'h000000, 1'b0},
        // a write in the middle of a stream drops the pending sample
        '{ROW_CFG,  5'd2,  24'h000000, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_BEAT, 5'd0,  24'h000005, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_CFG,  5'd17, 24'h000000, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_BEAT, 5'd0,  24'h000007, 1'b1, 1'b1, 24'h000007, 1'b1},
        '{ROW_CFG,  5'd1,  24'h000000, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_BEAT, 5'd0,  24'h000003, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_BEAT, 5'd0,  24'hFFFFFA, 1'b1, 1'b0, 24'h000000, 1'b0}
    };

    centered_moving_average_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_is_last   (s_is_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_average   (m_average),
        .m_last_out  (m_last_out)
    );

    always #6 aclk = ~aclk;

    initial begin
        foreach (history[i]) history[i] = '0;
    end

    function automatic void clear_history();
        foreach (history[i]) history[i] = '0;
        stream_depth = 0;
    endfunction

    // Add one mean at the tail of a queue.
    function automatic void append_mean(ref mean_beat_t q[$], input sample_t avg,
                                        input logic lst);
        mean_beat_t m;
        m.average  = avg;
        m.last_out = lst;
        q = {q, m};
    endfunction

    // Shift in one sample and work out every window mean it releases. Without
    // the last flag only the position half_width back from the newest sample
    // completes; the last flag releases every pending position down to the newest.
    task automatic window_means(input sample_t s, input logic last,
                                ref mean_beat_t outs[$]);
        longint acc;
        longint cnt;
        outs.delete();
        for (int i = LINE_LEN - 1; i > 0; i--) history[i] = history[i-1];
        history[0] = s;
        if (stream_depth < LINE_LEN) stream_depth++;
        for (int d = half_width; d >= 0; d--) begin
            if (d >= stream_depth) continue;
            if (d != half_width && !last) continue;
            acc = history[d];
            cnt = 1;
            // Skip neighbors past either end of the stream.
            for (int j = 1; j <= half_width; j++) begin
                if (j <= d) begin
                    acc += history[d-j];
                    cnt++;
                end
                if (d + j < stream_depth) begin
                    acc += history[d+j];
                    cnt++;
                end
            end
            append_mean(outs, sample_t'(acc / cnt), last && d == 0);
        end
        if (last) clear_history();
    endtask

    function automatic int unsigned draw_gap(bit steady);
        return steady ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic sample_t pick_sample(stream_style_t style);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (style == STYLE_TOP || (style == STYLE_MIXED && r == 0)) return SAMPLE_MAX;
        if (style == STYLE_BOTTOM || (style == STYLE_MIXED && r == 1)) return SAMPLE_MIN;
        if (style == STYLE_NEAR_ZERO || (style == STYLE_MIXED && r < 4))
            return sample_t'($urandom_range(0, 600)) - sample_t'(300);
        return sample_t'($urandom());
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Offer one beat, hold it until accepted, then queue the means it releases.
    // Lower valid only on a real gap so a back-to-back beat keeps it high.
    task automatic send_sample(input sample_t s, input logic last, input bit typed = 1'b0,
                               input sample_t want_avg = '0, input logic want_last = 1'b0);
        int unsigned gap;
        mean_beat_t  released [$];
        gap = draw_gap(send_steady);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_sample  <= s;
        s_is_last <= last;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        beats_sent++;
        window_means(s, last, released);
        if (typed) append_mean(means_due, want_avg, want_last);
        else foreach (released[i])
            append_mean(means_due, released[i].average, released[i].last_out);
    endtask

    // Stop offering, wait until every queued mean has come back, then give the
    // unit time to finish any beat that released nothing.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (means_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window_half(input logic [CFG_W-1:0] v);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        half_width = (int'(v) > HALF_MAX) ? HALF_MAX : int'(v);
        clear_history();
    endtask

    // Result side: draw a stall per beat, or take a long hold when one is
    // requested, then compare the accepted beat with the oldest queued mean.
    initial begin
        int unsigned gap;
        mean_beat_t  want;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            gap = (ready_hold != 0) ? ready_hold : draw_gap(recv_steady);
            ready_hold = 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (means_due.size() == 0) begin
                report_mismatch("result beat with nothing expected", m_average, 0);
            end else begin
                want = means_due.pop_front();
                if (m_average !== want.average)
                    report_mismatch("average", m_average, want.average);
                if (m_last_out !== want.last_out)
                    report_mismatch("last_out", m_last_out, want.last_out);
            end
        end
    end

    initial begin
        int            phase;
        int            streams;
        int            len;
        int unsigned   r;
        logic [CFG_W-1:0] half;
        bit            closed;
        stream_style_t style;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed plan.
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                write_window_half(plan[i].half);
            else
                send_sample(plan[i].sample, plan[i].last, plan[i].typed,
                            plan[i].want_avg, plan[i].want_last);
        end

        // Random phases: pick a window, then run a few streams through it.
        phase = 0;
        while (beats_sent < TARGET_BEATS) begin
            r = $urandom_range(0, 5);
            if (r == 0) half = '0;
            else if (r == 1) half = CFG_W'(HALF_MAX);
            else if (r == 2) half = '1;
            else half = CFG_W'($urandom_range(0, 31));
            send_steady = ($urandom_range(0, 3) == 0);
            recv_steady = ($urandom_range(0, 3) == 0);
            streams = $urandom_range(1, 4);

            // Once, stall the result side hard under a long full-window stream
            // so the unit backs up and throttles its input.
            if (phase == 3) begin
                half        = CFG_W'(HALF_MAX);
                send_steady = 1'b1;
                streams     = 1;
            end
            write_window_half(half);
            if (phase == 3) ready_hold = PRESSURE_HOLD;

            for (int s = 0; s < streams; s++) begin
                r = $urandom_range(0, 9);
                if (phase == 3) len = 48;
                else if (r < 6) len = $urandom_range(1, 8);
                else if (r < 9) len = $urandom_range(9, 20);
                else len = $urandom_range(30, 45);
                r = $urandom_range(0, 9);
                style = (r == 0) ? STYLE_TOP : (r == 1) ? STYLE_BOTTOM :
                        (r == 2) ? STYLE_NEAR_ZERO : STYLE_MIXED;
                // Leave some streams open; they run on or get cut by a write.
                closed = (phase == 3) || ($urandom_range(0, 7) != 0);
                for (int i = 0; i < len; i++)
                    send_sample(pick_sample(style), closed && i == len - 1);
            end
            phase++;
        end

        drain_results();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop far past the slowest legal run.
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
